// ===== design/csid_pkg.sv =====
// Shared constants, types and elaboration-time CRC tables for the chip short ID generator.
package csid_pkg;

    // Message layout: five configured words and the salt, 32 bits each, LSB first
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned MSG_WORDS = 6;
    localparam int unsigned MSG_BITS  = WORD_W * MSG_WORDS;

    // Reflected CRC-32 (IEEE 802.3)
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Output framing
    localparam int unsigned NUM_CHARS  = 13;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned CHAR_IDX_W = 4;
    localparam int unsigned DIGIT_W    = 5;
    localparam int unsigned PACK_W     = 64;
    localparam int unsigned REST_W     = PACK_W - 4;
    localparam int unsigned HALF_W     = 16;
    localparam logic [CHAR_IDX_W-1:0] LAST_CHAR_IDX = CHAR_IDX_W'(NUM_CHARS - 1);

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UID_LOW     = 3'd0,
        REG_UID_MID     = 3'd1,
        REG_UID_HIGH    = 3'd2,
        REG_DEVICE_ID   = 3'd3,
        REG_REVISION_ID = 3'd4
    } cfg_reg_t;

    // One column per message bit of a word: its effect on the CRC register
    typedef logic [WORD_W-1:0][31:0] crc_mat_t;

    // Linear effect of each bit of message word w on the final CRC (zero init, no inversion)
    function automatic crc_mat_t crc_word_mat(int unsigned w);
        crc_mat_t    m;
        logic [31:0] c;
        for (int unsigned j = 0; j < WORD_W; j++) begin
            c = '0;
            for (int unsigned n = 0; n < MSG_BITS; n++) begin
                if (n == w * WORD_W + j) begin
                    c[0] = ~c[0];
                end
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            m[j] = c;
        end
        return m;
    endfunction

    // CRC of an all-zero message with the standard init and final inversion
    function automatic logic [31:0] crc_zero_msg();
        logic [31:0] c;
        c = CRC_INIT;
        for (int unsigned n = 0; n < MSG_BITS; n++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    // GF(2) matrix times vector: XOR of the columns whose input bit is set
    function automatic logic [31:0] gf2_apply(crc_mat_t m, logic [WORD_W-1:0] v);
        logic [31:0] acc;
        acc = '0;
        for (int unsigned j = 0; j < WORD_W; j++) begin
            acc = acc ^ (m[j] & {32{v[j]}});
        end
        return acc;
    endfunction

    localparam crc_mat_t    MAT_UID_LOW  = crc_word_mat(0);
    localparam crc_mat_t    MAT_UID_MID  = crc_word_mat(1);
    localparam crc_mat_t    MAT_UID_HIGH = crc_word_mat(2);
    localparam crc_mat_t    MAT_DEVICE   = crc_word_mat(3);
    localparam crc_mat_t    MAT_REVISION = crc_word_mat(4);
    localparam crc_mat_t    MAT_SALT     = crc_word_mat(5);
    localparam logic [31:0] CRC_ZERO     = crc_zero_msg();

    // Crockford Base32 alphabet in ASCII
    localparam logic [CHAR_W-1:0] CROCK_ALPHA [32] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
        7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
        7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
    };

endpackage

// ===== design/chip_short_id_generator.sv =====
// Top level: salt input register, CRC hash and Crockford Base32 character serializer.
// Each accepted salt yields 13 transfers on the m_ channel, one ASCII character each, most
// significant first, with m_char_index 0..12 and m_last_char on the thirteenth. A salt is
// held in the input register until the output register is free to load its characters;
// the output register sends one character per cycle while m_ready is high, and the next
// salt is taken while the current characters are still going out.
// Configuration writes (cfg_ready is always high) take effect at once; indexes above 4 are
// ignored.
module chip_short_id_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [31:0]                        s_salt,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [csid_pkg::CHAR_W-1:0]        m_id_char,
    output logic [csid_pkg::CHAR_IDX_W-1:0]    m_char_index,
    output logic                               m_last_char,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);
    import csid_pkg::*;

    logic                  in_valid_reg;
    logic [WORD_W-1:0]     salt_reg;
    logic [PACK_W-1:0]     pack_word;

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic [CHAR_IDX_W-1:0] index_reg;
    logic                  last_reg;
    logic [REST_W-1:0]     rest_reg;

    logic                  s_fire;
    logic                  m_fire;
    logic                  out_load;
    logic                  out_step;

    csid_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .salt      (salt_reg),
        .pack_word (pack_word)
    );

    // Handshake control
    assign m_fire   = out_valid_reg && m_ready;
    assign out_load = in_valid_reg && (!out_valid_reg || (m_fire && last_reg));
    assign out_step = m_fire && !last_reg;
    assign s_ready  = !in_valid_reg || out_load;
    assign s_fire   = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (out_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            salt_reg <= s_salt;
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_fire && last_reg) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Character serializer: top digit holds 4 bits, then 12 five-bit digits
    always_ff @(posedge aclk) begin
        if (out_load) begin
            char_reg  <= CROCK_ALPHA[{1'b0, pack_word[PACK_W-1:REST_W]}];
            rest_reg  <= pack_word[REST_W-1:0];
            index_reg <= '0;
            last_reg  <= 1'b0;
        end else if (out_step) begin
            char_reg  <= CROCK_ALPHA[rest_reg[REST_W-1:REST_W-DIGIT_W]];
            rest_reg  <= {rest_reg[REST_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            index_reg <= index_reg + CHAR_IDX_W'(1);
            last_reg  <= (index_reg + CHAR_IDX_W'(1)) == LAST_CHAR_IDX;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_id_char    = char_reg;
    assign m_char_index = index_reg;
    assign m_last_char  = last_reg;

    // Last flag tracks the final index
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (last_reg == (index_reg == LAST_CHAR_IDX)))
        else $error("last flag out of step with character index");

    // A held salt is the only reason to refuse input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // A non-final transfer moves on to the next character
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_step |=> (out_valid_reg && index_reg == $past(index_reg) + CHAR_IDX_W'(1)))
        else $error("character index did not advance");

    // A waiting salt starts a fresh identifier right after the final character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && last_reg && in_valid_reg) |=> (out_valid_reg && index_reg == '0))
        else $error("next identifier not started after last character");

endmodule

// ===== design/csid_hash.sv =====
// Configuration registers and the combinational CRC-32 over the 24-byte ID message.
module csid_hash (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csid_pkg::WORD_W-1:0]         cfg_data,
    input  logic [csid_pkg::WORD_W-1:0]         salt,
    output logic [csid_pkg::PACK_W-1:0]         pack_word
);
    import csid_pkg::*;

    // Per-word CRC contributions, folded in when the register is written
    logic [31:0]       contrib_reg [MSG_WORDS-1];
    logic [HALF_W-1:0] dev_lo_reg;
    logic [HALF_W-1:0] rev_lo_reg;
    logic [31:0]       crc;

    assign cfg_ready = 1'b1;

    // Register writes; unused indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int unsigned i = 0; i < MSG_WORDS - 1; i++) begin
                contrib_reg[i] <= '0;
            end
            dev_lo_reg <= '0;
            rev_lo_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_UID_LOW:  contrib_reg[0] <= gf2_apply(MAT_UID_LOW, cfg_data);
                REG_UID_MID:  contrib_reg[1] <= gf2_apply(MAT_UID_MID, cfg_data);
                REG_UID_HIGH: contrib_reg[2] <= gf2_apply(MAT_UID_HIGH, cfg_data);
                REG_DEVICE_ID: begin
                    contrib_reg[3] <= gf2_apply(MAT_DEVICE, cfg_data);
                    dev_lo_reg     <= cfg_data[HALF_W-1:0];
                end
                REG_REVISION_ID: begin
                    contrib_reg[4] <= gf2_apply(MAT_REVISION, cfg_data);
                    rev_lo_reg     <= cfg_data[HALF_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // CRC is affine in the message: zero-message CRC XOR every word's contribution
    assign crc = CRC_ZERO ^ contrib_reg[0] ^ contrib_reg[1] ^ contrib_reg[2]
               ^ contrib_reg[3] ^ contrib_reg[4] ^ gf2_apply(MAT_SALT, salt);

    assign pack_word = {crc, dev_lo_reg, rev_lo_reg};

endmodule

// ===== sim/chip_short_id_generator_test.sv =====
// Self-checking testbench for the chip short ID generator: salts in, Crockford characters out.
module chip_short_id_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csid_pkg::*;

    localparam int unsigned ID_CHARS      = 13;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned TAIL_CYCLES   = 40;
    localparam int unsigned SALT_TRIES    = 20000;
    localparam logic [31:0] CRC32_POLY    = 32'hEDB8_8320;
    localparam logic [2:0]  CFG_IDX_TOP   = 3'd7;
    localparam logic [8*32-1:0] CROCKFORD_SET = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

    typedef enum logic [1:0] {
        JOB_SALT,
        JOB_WRITE,
        JOB_DRAIN,
        JOB_PHASE
    } job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        int unsigned send_idle;
        int unsigned recv_idle;
    } job_t;

    typedef struct packed {
        logic [CHAR_W-1:0]     ch;
        logic [CHAR_IDX_W-1:0] pos;
        logic                  last;
    } id_char_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [31:0]           s_salt       = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [CHAR_W-1:0]     m_id_char;
    logic [CHAR_IDX_W-1:0] m_char_index;
    logic                  m_last_char;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [31:0]           cfg_data     = '0;

    job_t        jobs[$];
    id_char_t    expected_chars[$];
    logic [4:0][31:0] cfg_shadow = '0;
    logic [4:0][31:0] plan_regs  = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned salts_sent    = 0;
    int unsigned salts_taken   = 0;
    int unsigned writes_sent   = 0;
    int unsigned writes_taken  = 0;
    int unsigned stuck_cycles  = 0;
    int unsigned mismatches    = 0;

    chip_short_id_generator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_salt       (s_salt),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_id_char    (m_id_char),
        .m_char_index (m_char_index),
        .m_last_char  (m_last_char),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Reflected CRC-32 over the 24-byte message, byte 0 in bits 7..0
    function automatic logic [31:0] message_crc(logic [191:0] msg);
        logic [31:0] c;
        c = '1;
        for (int b = 0; b < 24; b++) begin
            c = c ^ {24'd0, msg[8*b +: 8]};
            for (int i = 0; i < 8; i++) begin
                c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
            end
        end
        return ~c;
    endfunction

    // 64-bit ID word: CRC over the top, then the low halves of device and revision
    function automatic logic [63:0] short_id_word(logic [4:0][31:0] regs, logic [31:0] salt);
        logic [31:0] crc;
        crc = message_crc({salt, regs});
        return {crc, regs[REG_DEVICE_ID][15:0], regs[REG_REVISION_ID][15:0]};
    endfunction

    // Look for a salt whose CRC matches a bit pattern under the given registers
    function automatic logic [31:0] find_salt(logic [4:0][31:0] regs, logic [31:0] mask,
                                              logic [31:0] pattern);
        logic [31:0] cand;
        logic [63:0] w;
        cand = $urandom;
        for (int t = 0; t < SALT_TRIES; t++) begin
            cand = $urandom;
            w = short_id_word(regs, cand);
            if ((w[63:32] & mask) == pattern) begin
                break;
            end
        end
        return cand;
    endfunction

    function automatic void queue_salt(logic [31:0] v);
        job_t j;
        j.kind = JOB_SALT;
        j.idx = '0;
        j.data = v;
        j.send_idle = 0;
        j.recv_idle = 0;
        jobs.push_back(j);
    endfunction

    function automatic void queue_write(logic [2:0] idx, logic [31:0] v);
        job_t j;
        j.kind = JOB_WRITE;
        j.idx = idx;
        j.data = v;
        j.send_idle = 0;
        j.recv_idle = 0;
        jobs.push_back(j);
        if (idx <= REG_REVISION_ID) begin
            plan_regs[idx] = v;
        end
    endfunction

    function automatic void queue_control(job_kind_t kind, int unsigned s_pct,
                                          int unsigned r_pct);
        job_t j;
        j.kind = kind;
        j.idx = '0;
        j.data = '0;
        j.send_idle = s_pct;
        j.recv_idle = r_pct;
        jobs.push_back(j);
    endfunction

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Driver: at most one job per falling edge once the previous transfer has completed
    always @(negedge aclk) begin : driver
        logic next_s_valid;
        logic next_cfg_valid;
        logic busy;
        busy = (salts_sent != salts_taken) || (writes_sent != writes_taken);
        next_s_valid = 1'b0;
        next_cfg_valid = 1'b0;
        if (aresetn && !busy) begin
            if (jobs.size() != 0) begin
                case (jobs[0].kind)
                    JOB_SALT: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            next_s_valid = 1'b1;
                            s_salt <= jobs[0].data;
                            salts_sent++;
                            void'(jobs.pop_front());
                        end
                    end
                    JOB_WRITE: begin
                        if (expected_chars.size() == 0) begin
                            next_cfg_valid = 1'b1;
                            cfg_index <= jobs[0].idx;
                            cfg_data <= jobs[0].data;
                            writes_sent++;
                            void'(jobs.pop_front());
                        end
                    end
                    JOB_DRAIN: begin
                        if (expected_chars.size() == 0) begin
                            void'(jobs.pop_front());
                        end
                    end
                    default: begin
                        send_idle_pct = jobs[0].send_idle;
                        recv_idle_pct = jobs[0].recv_idle;
                        void'(jobs.pop_front());
                    end
                endcase
            end
            s_valid <= next_s_valid;
            cfg_valid <= next_cfg_valid;
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on salt transfers, track registers, check characters
    always @(posedge aclk) begin : monitor
        logic [63:0] id_word;
        logic [64:0] id_ext;
        logic [4:0]  digit;
        id_char_t    want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index <= REG_REVISION_ID) begin
                    cfg_shadow[cfg_index] = cfg_data;
                end
                writes_taken++;
            end
            if (s_valid && s_ready) begin
                id_word = short_id_word(cfg_shadow, s_salt);
                id_ext = {1'b0, id_word};
                for (int k = 0; k < ID_CHARS; k++) begin
                    digit = id_ext[5*(ID_CHARS-1-k) +: 5];
                    want.ch = CROCKFORD_SET[8*(31-digit) +: CHAR_W];
                    want.pos = CHAR_IDX_W'(k);
                    want.last = (k == ID_CHARS - 1);
                    expected_chars.push_back(want);
                end
                salts_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("character with nothing expected", 32'(m_id_char), 0);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_id_char !== want.ch) begin
                        report_mismatch("id_char", 32'(m_id_char), 32'(want.ch));
                    end
                    if (m_char_index !== want.pos) begin
                        report_mismatch("char_index", 32'(m_char_index), 32'(want.pos));
                    end
                    if (m_last_char !== want.last) begin
                        report_mismatch("last_char", 32'(m_last_char), 32'(want.last));
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial begin : watchdog
        while (stuck_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("chip_short_id_generator_test: errors");
        $finish;
    end

    // Stimulus and end of run
    initial begin : stimulus
        logic [2:0] idx;
        queue_control(JOB_PHASE, 14, 66);

        // Reset registers, extreme salts
        queue_salt('0);
        queue_salt('1);

        // All registers at all ones
        for (int r = REG_UID_LOW; r <= REG_REVISION_ID; r++) begin
            queue_write(3'(r), '1);
        end
        queue_salt('0);
        queue_salt('1);
        queue_salt(32'hA5A5_5A5A);

        // Writes to unused indexes must leave the registers alone
        for (int r = REG_REVISION_ID + 1; r <= CFG_IDX_TOP; r++) begin
            queue_write(3'(r), $urandom);
        end
        queue_salt('0);

        // Random registers; leading zero characters and the largest top character
        for (int r = REG_UID_LOW; r <= REG_REVISION_ID; r++) begin
            queue_write(3'(r), $urandom);
        end
        queue_salt(find_salt(plan_regs, 32'hFF80_0000, 32'h0000_0000));
        queue_salt(find_salt(plan_regs, 32'hF000_0000, 32'hF000_0000));
        queue_salt($urandom);

        // Back to all zeros
        for (int r = REG_UID_LOW; r <= REG_REVISION_ID; r++) begin
            queue_write(3'(r), '0);
        end
        queue_salt(find_salt(plan_regs, 32'hF000_0000, 32'h0000_0000));
        queue_salt($urandom);

        // Random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                queue_control(JOB_PHASE, 66, 14);
            end else if (ph == 2) begin
                queue_control(JOB_PHASE, 0, 0);
            end
            for (int n = 0; n < 86; n++) begin
                if ($urandom_range(17) == 0) begin
                    if ($urandom_range(7) == 0) begin
                        idx = 3'($urandom_range(CFG_IDX_TOP, REG_REVISION_ID + 1));
                    end else begin
                        idx = 3'($urandom_range(REG_REVISION_ID, REG_UID_LOW));
                    end
                    queue_write(idx, pick_word());
                end
                if (n == 43) begin
                    queue_control(JOB_DRAIN, 0, 0);
                end
                queue_salt(pick_word());
            end
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (jobs.size() != 0 || salts_sent != salts_taken || writes_sent != writes_taken
               || expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_chars.size() != 0) begin
            report_mismatch("characters never sent", expected_chars.size(), 0);
        end
        if (mismatches == 0) begin
            $display("chip_short_id_generator_test: clean");
        end else begin
            $display("chip_short_id_generator_test: errors");
        end
        $finish;
    end

endmodule
